/* hdl/mpus_pkg.sv */
`default_nettype none

package mpus_pkg;

  // Configuration port geometry
  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned TimerW   = 16;

  // Register indexes (byte address = 4 * index)
  typedef enum logic [2:0] {
    REG_DISCHARGE    = 3'd0,
    REG_PG_TIMEOUT   = 3'd1,
    REG_SETTLE       = 3'd2,
    REG_KEY_HOLD     = 3'd3,
    REG_STATUS_TMO   = 3'd4,
    REG_REG_TIMEOUT  = 3'd5,
    REG_SPARE6       = 3'd6,
    REG_SPARE7       = 3'd7
  } reg_idx_e;

  // Register reset values, in ms ticks
  localparam logic [TimerW-1:0] DischargeRst  = 16'd1000;
  localparam logic [TimerW-1:0] PgTimeoutRst  = 16'd100;
  localparam logic [TimerW-1:0] SettleRst     = 16'd500;
  localparam logic [TimerW-1:0] KeyHoldRst    = 16'd1250;
  localparam logic [TimerW-1:0] StatusTmoRst  = 16'd5000;
  localparam logic [TimerW-1:0] RegTimeoutRst = 16'(30 * 1000);

  localparam logic [TimerW-1:0] ElapsedMax = '1;

  // Reported sequence state codes
  localparam logic [2:0] SEQ_IDLE         = 3'd0;
  localparam logic [2:0] SEQ_DISCHARGE    = 3'd1;
  localparam logic [2:0] SEQ_WAIT_PG      = 3'd2;
  localparam logic [2:0] SEQ_SETTLE       = 3'd3;
  localparam logic [2:0] SEQ_KEY          = 3'd4;
  localparam logic [2:0] SEQ_STATUS       = 3'd5;
  localparam logic [2:0] SEQ_REGISTRATION = 3'd6;
  localparam logic [2:0] SEQ_NORMAL       = 3'd7;

  // Sequencer phase, one-hot
  typedef enum logic [7:0] {
    PH_IDLE         = 8'b0000_0001,
    PH_DISCHARGE    = 8'b0000_0010,
    PH_WAIT_PG      = 8'b0000_0100,
    PH_SETTLE       = 8'b0000_1000,
    PH_KEY          = 8'b0001_0000,
    PH_STATUS       = 8'b0010_0000,
    PH_REGISTRATION = 8'b0100_0000,
    PH_NORMAL       = 8'b1000_0000
  } phase_e;

  // Timer settings from the register block to the sequencer
  typedef struct packed {
    logic [TimerW-1:0] discharge_ms;
    logic [TimerW-1:0] power_good_timeout_ms;
    logic [TimerW-1:0] settle_ms;
    logic [TimerW-1:0] key_hold_ms;
    logic [TimerW-1:0] status_timeout_ms;
    logic [TimerW-1:0] registration_timeout_ms;
  } cfg_t;

  // One result per tick
  typedef struct packed {
    logic       power_off;
    logic       key_level;
    logic       pg_drive_low;
    logic [2:0] seq_state;
    logic       ready_res;
  } result_t;

  function automatic logic [2:0] phase_code(phase_e ph);
    logic [2:0] code;
    unique case (ph)
      PH_IDLE:         code = SEQ_IDLE;
      PH_DISCHARGE:    code = SEQ_DISCHARGE;
      PH_WAIT_PG:      code = SEQ_WAIT_PG;
      PH_SETTLE:       code = SEQ_SETTLE;
      PH_KEY:          code = SEQ_KEY;
      PH_STATUS:       code = SEQ_STATUS;
      PH_REGISTRATION: code = SEQ_REGISTRATION;
      PH_NORMAL:       code = SEQ_NORMAL;
      default:         code = SEQ_IDLE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

/* hdl/mpus_in_if.sv */
`default_nettype none

// Tick channel: sampled pin levels
interface mpus_in_if;
  logic valid;
  logic ready;
  logic power_good_high;
  logic status_high;
  logic registered;

  modport source (output valid, output power_good_high, output status_high,
                  output registered, input ready);
  modport sink (input valid, input power_good_high, input status_high,
                input registered, output ready);
endinterface

`default_nettype wire

/* hdl/mpus_out_if.sv */
`default_nettype none

// Result channel: driven pin levels and sequence state
interface mpus_out_if;
  logic       valid;
  logic       ready;
  logic       power_off;
  logic       key_level;
  logic       pg_drive_low;
  logic [2:0] seq_state;
  logic       ready_res;

  modport source (output valid, output power_off, output key_level,
                  output pg_drive_low, output seq_state, output ready_res,
                  input ready);
  modport sink (input valid, input power_off, input key_level,
                input pg_drive_low, input seq_state, input ready_res,
                output ready);
endinterface

`default_nettype wire

/* hdl/mpus_cfg.sv */
`default_nettype none

module mpus_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [mpus_pkg::CfgAddrW-1:0]  paddr,
  input  wire logic [mpus_pkg::CfgDataW-1:0]  pwdata,
  output logic      [mpus_pkg::CfgDataW-1:0]  prdata,
  output logic                                pready,
  output mpus_pkg::cfg_t                      cfg_o
);

  mpus_pkg::cfg_t   cfg_q, cfg_d;
  mpus_pkg::reg_idx_e idx;
  logic             wr_en;
  logic [mpus_pkg::TimerW-1:0] wdata;
  logic [mpus_pkg::TimerW-1:0] rdata;

  assign pready = 1'b1;
  assign idx    = mpus_pkg::reg_idx_e'(paddr[mpus_pkg::CfgAddrW-1:2]);
  assign wr_en  = psel & penable & pwrite & pready;
  assign wdata  = pwdata[mpus_pkg::TimerW-1:0];

  // Write decode; spare indexes are ignored
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        mpus_pkg::REG_DISCHARGE:   cfg_d.discharge_ms            = wdata;
        mpus_pkg::REG_PG_TIMEOUT:  cfg_d.power_good_timeout_ms   = wdata;
        mpus_pkg::REG_SETTLE:      cfg_d.settle_ms               = wdata;
        mpus_pkg::REG_KEY_HOLD:    cfg_d.key_hold_ms             = wdata;
        mpus_pkg::REG_STATUS_TMO:  cfg_d.status_timeout_ms       = wdata;
        mpus_pkg::REG_REG_TIMEOUT: cfg_d.registration_timeout_ms = wdata;
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      mpus_pkg::REG_DISCHARGE:   rdata = cfg_q.discharge_ms;
      mpus_pkg::REG_PG_TIMEOUT:  rdata = cfg_q.power_good_timeout_ms;
      mpus_pkg::REG_SETTLE:      rdata = cfg_q.settle_ms;
      mpus_pkg::REG_KEY_HOLD:    rdata = cfg_q.key_hold_ms;
      mpus_pkg::REG_STATUS_TMO:  rdata = cfg_q.status_timeout_ms;
      mpus_pkg::REG_REG_TIMEOUT: rdata = cfg_q.registration_timeout_ms;
      default:                   rdata = '0;
    endcase
  end

  assign prdata = {{(mpus_pkg::CfgDataW - mpus_pkg::TimerW){1'b0}}, rdata};
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.discharge_ms            <= mpus_pkg::DischargeRst;
      cfg_q.power_good_timeout_ms   <= mpus_pkg::PgTimeoutRst;
      cfg_q.settle_ms               <= mpus_pkg::SettleRst;
      cfg_q.key_hold_ms             <= mpus_pkg::KeyHoldRst;
      cfg_q.status_timeout_ms       <= mpus_pkg::StatusTmoRst;
      cfg_q.registration_timeout_ms <= mpus_pkg::RegTimeoutRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/mpus_core.sv */
`default_nettype none

module mpus_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire mpus_pkg::cfg_t cfg_i,
  mpus_in_if.sink          in_i,
  mpus_out_if.source       out_o
);

  mpus_pkg::phase_e            phase_q, phase_d;
  logic [mpus_pkg::TimerW-1:0] elapsed_q, elapsed_d, el_inc;
  logic                        power_off_q, power_off_d;
  logic                        key_rel_q, key_rel_d;
  logic                        pg_drv_q, pg_drv_d;
  mpus_pkg::result_t           res_q, res_d;
  logic                        out_valid_q;
  logic                        accept;
  logic                        go;

  // Take a request whenever the result register is empty or being drained
  assign in_i.ready = ~out_valid_q | out_o.ready;
  assign accept     = in_i.valid & in_i.ready;

  // Saturating tick count
  assign el_inc = (elapsed_q == mpus_pkg::ElapsedMax) ? elapsed_q : elapsed_q + 1'b1;

  // Sequencer next state; any transition clears the count
  always_comb begin
    phase_d     = phase_q;
    power_off_d = power_off_q;
    key_rel_d   = key_rel_q;
    pg_drv_d    = pg_drv_q;
    go          = 1'b0;
    unique case (phase_q)
      mpus_pkg::PH_IDLE: begin
        power_off_d = 1'b1;
        pg_drv_d    = 1'b1;
        phase_d     = mpus_pkg::PH_DISCHARGE;
        go          = 1'b1;
      end
      mpus_pkg::PH_DISCHARGE: begin
        if (el_inc > cfg_i.discharge_ms) begin
          pg_drv_d    = 1'b0;
          power_off_d = 1'b0;
          phase_d     = mpus_pkg::PH_WAIT_PG;
          go          = 1'b1;
        end
      end
      mpus_pkg::PH_WAIT_PG: begin
        priority if (in_i.power_good_high) begin
          phase_d = mpus_pkg::PH_SETTLE;
          go      = 1'b1;
        end else if (el_inc > cfg_i.power_good_timeout_ms) begin
          phase_d = mpus_pkg::PH_IDLE;
          go      = 1'b1;
        end
      end
      mpus_pkg::PH_SETTLE: begin
        if (el_inc > cfg_i.settle_ms) begin
          key_rel_d = 1'b0;
          phase_d   = mpus_pkg::PH_KEY;
          go        = 1'b1;
        end
      end
      mpus_pkg::PH_KEY: begin
        if (el_inc > cfg_i.key_hold_ms) begin
          key_rel_d = 1'b1;
          phase_d   = mpus_pkg::PH_STATUS;
          go        = 1'b1;
        end
      end
      mpus_pkg::PH_STATUS: begin
        priority if (in_i.status_high) begin
          phase_d = mpus_pkg::PH_REGISTRATION;
          go      = 1'b1;
        end else if (el_inc > cfg_i.status_timeout_ms) begin
          phase_d = mpus_pkg::PH_IDLE;
          go      = 1'b1;
        end
      end
      mpus_pkg::PH_REGISTRATION: begin
        // timeout wins over registration on the same tick
        priority if (el_inc > cfg_i.registration_timeout_ms) begin
          phase_d = mpus_pkg::PH_IDLE;
          go      = 1'b1;
        end else if (in_i.registered) begin
          phase_d = mpus_pkg::PH_NORMAL;
          go      = 1'b1;
        end
      end
      mpus_pkg::PH_NORMAL: begin
        phase_d = mpus_pkg::PH_NORMAL;
      end
      default: begin
        phase_d = mpus_pkg::PH_IDLE;
        go      = 1'b1;
      end
    endcase
    elapsed_d = go ? '0 : el_inc;
  end

  // Result from the post-update state
  always_comb begin
    res_d.power_off    = power_off_d;
    res_d.key_level    = key_rel_d;
    res_d.pg_drive_low = pg_drv_d;
    res_d.seq_state    = mpus_pkg::phase_code(phase_d);
    res_d.ready_res    = (phase_d == mpus_pkg::PH_NORMAL);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= mpus_pkg::PH_IDLE;
      elapsed_q   <= '0;
      power_off_q <= 1'b1;
      key_rel_q   <= 1'b1;
      pg_drv_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q     <= phase_d;
        elapsed_q   <= elapsed_d;
        power_off_q <= power_off_d;
        key_rel_q   <= key_rel_d;
        pg_drv_q    <= pg_drv_d;
      end
      out_valid_q <= accept | (out_valid_q & ~out_o.ready);
    end
  end

  // Result payload register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.power_off    = res_q.power_off;
  assign out_o.key_level    = res_q.key_level;
  assign out_o.pg_drive_low = res_q.pg_drive_low;
  assign out_o.seq_state    = res_q.seq_state;
  assign out_o.ready_res    = res_q.ready_res;

`ifndef ASSERT_OFF
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted tick produced no result");

  a_key_only_in_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.key_level) |-> (res_q.seq_state == mpus_pkg::SEQ_KEY))
    else $error("key pressed outside key phase");

  a_pg_follows_power: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.pg_drive_low == res_q.power_off))
    else $error("power-good drive and power cut disagree");

  a_ready_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.ready_res == (res_q.seq_state == mpus_pkg::SEQ_NORMAL)))
    else $error("ready flag does not match normal state");
`endif

endmodule

`default_nettype wire

/* hdl/modem_power_up_sequencer_top.sv */
`default_nettype none

// The result of a tick is registered at the accepting edge and is valid in the next cycle.
// Throughput: one tick per clock cycle; the single result register is drained and refilled
//   in the same cycle, so the input only stalls while that register is held by the sink.
// Reset (rst_ni, async low): sequencer idle, count zero, power cut, key released,
//   power-good not driven, result register empty, timer registers at their defaults.
module modem_power_up_sequencer_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [mpus_pkg::CfgAddrW-1:0]  paddr,
  input  wire logic [mpus_pkg::CfgDataW-1:0]  pwdata,
  output logic      [mpus_pkg::CfgDataW-1:0]  prdata,
  output logic                                pready,
  mpus_in_if.sink                             in_i,
  mpus_out_if.source                          out_o
);

  mpus_pkg::cfg_t cfg;

  // Timer registers
  mpus_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer and result register
  mpus_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire
